FILE: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, widths and character classes for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS   = 20;
	localparam int FIFO_DEPTH  = 8;
	localparam int PTR_BITS    = $clog2(FIFO_DEPTH);

	localparam logic [4:0] K_EOF    = 5'd0;
	localparam logic [4:0] K_GT     = 5'd12;
	localparam logic [4:0] K_GE     = 5'd13;
	localparam logic [4:0] K_LT     = 5'd14;
	localparam logic [4:0] K_LE     = 5'd15;
	localparam logic [4:0] K_ASSIGN = 5'd16;
	localparam logic [4:0] K_EQ     = 5'd17;
	localparam logic [4:0] K_NE     = 5'd18;
	localparam logic [4:0] K_STAR   = 5'd19;
	localparam logic [4:0] K_POW    = 5'd20;
	localparam logic [4:0] K_SLASH  = 5'd21;
	localparam logic [4:0] K_DOT    = 5'd22;
	localparam logic [4:0] K_STRING = 5'd23;
	localparam logic [4:0] K_IDENT  = 5'd24;
	localparam logic [4:0] K_INT    = 5'd25;
	localparam logic [4:0] K_DEC    = 5'd26;
	localparam logic [4:0] K_ERR    = 5'd27;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_UNKNOWN  = 3'd1;
	localparam logic [2:0] E_UNTERM   = 3'd2;
	localparam logic [2:0] E_ENDPOINT = 3'd3;
	localparam logic [2:0] E_OVERFLOW = 3'd4;
	localparam logic [2:0] E_EXTRAPT  = 3'd5;

	typedef enum logic [2:0] {
		OP_NONE, OP_GT, OP_LT, OP_ASSIGN, OP_BANG, OP_STAR, OP_SLASH
	} op_t;

	typedef struct packed {
		logic [4:0]             kind;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] len;
		logic [LINE_BITS-1:0]   line;
		logic [30:0]            val;
		logic [2:0]             err;
	} tok_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	// kind of a token that is complete in one byte, zero if none
	function automatic logic [4:0] single_kind(input logic [7:0] c);
		logic [4:0] k;
		k = 5'd0;
		unique case (c)
			"(": k = 5'd1;
			")": k = 5'd2;
			"[": k = 5'd3;
			"]": k = 5'd4;
			"{": k = 5'd5;
			"}": k = 5'd6;
			",": k = 5'd7;
			";": k = 5'd8;
			"+": k = 5'd9;
			"-": k = 5'd10;
			"%": k = 5'd11;
			default: k = 5'd0;
		endcase
		return k;
	endfunction

	function automatic op_t op_code(input logic [7:0] c);
		op_t o;
		o = OP_NONE;
		unique case (c)
			">": o = OP_GT;
			"<": o = OP_LT;
			"=": o = OP_ASSIGN;
			"!": o = OP_BANG;
			"*": o = OP_STAR;
			"/": o = OP_SLASH;
			default: o = OP_NONE;
		endcase
		return o;
	endfunction

endpackage

FILE: design/source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming maximal-munch tokenizer, one source byte per input word.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with symbol, has_symbol, end_of_source.
// A word is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with one token per word; last_of_run
// marks the final token caused by one input word (an input word gives zero
// to three tokens).
// Datapath: an input word is registered in the input register, scanned from
// there once the queue has room, and its tokens land in an 8-entry result
// queue whose head drives the output.
// Throughput: one input word per cycle. The scan stage advances only while
// the queue has room for three tokens, so the output port, one token per
// cycle, sets the rate when words give several tokens.
// Reset: the scanner returns to idle at offset 0, line 1, and the queue
// empties. An end_of_source word resets the scanner alike after emitting Eof.
// Receiver stall: the head token holds; once six or more tokens wait in the
// queue and a word is in the input register, in_stall rises and holds it there.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top import stt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             symbol,
	input  logic                   has_symbol,
	input  logic                   end_of_source,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [4:0]             token_kind,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [OFFSET_BITS-1:0] lexeme_length,
	output logic [LINE_BITS-1:0]   line_number,
	output logic [30:0]            integer_value,
	output logic [2:0]             error_code,
	output logic                   last_of_run
);

	typedef enum logic [2:0] {
		M_IDLE, M_OP, M_DOT, M_STRING, M_IDENT, M_INT, M_FRAC, M_COMMENT
	} mode_t;

	typedef struct packed {
		logic vld;
		tok_t t;
	} pend_t;

	typedef struct packed {
		tok_t t;
		logic last;
	} entry_t;

	// input register
	logic       valid_s1;
	logic [7:0] sym_s1;
	logic       has_s1;
	logic       eos_s1;

	// scanner state
	mode_t                  mode_q;
	op_t                    op_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] ts_q;
	logic [LINE_BITS-1:0]   ln_q;
	logic [31:0]            acc_q;
	logic                   ov_q;
	logic                   ex_q;
	logic                   ewp_q;

	// result queue
	entry_t              mem_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [PTR_BITS:0]   cnt_q;

	logic                   room;
	logic                   proc;
	logic                   pop;
	mode_t                  m_n;
	op_t                    op_n;
	logic [OFFSET_BITS-1:0] off_n;
	logic [OFFSET_BITS-1:0] ts_n;
	logic [LINE_BITS-1:0]   ln_n;
	logic [31:0]            acc_n;
	logic                   ov_n;
	logic                   ex_n;
	logic                   ewp_n;
	tok_t                   em [3];
	logic [1:0]             n_em;

	// token left pending by the current mode, ending before offset off
	function automatic pend_t pending(input mode_t m, input op_t op,
			input logic [OFFSET_BITS-1:0] ts, input logic [OFFSET_BITS-1:0] off,
			input logic [LINE_BITS-1:0] ln, input logic [31:0] acc,
			input logic ov, input logic ex, input logic ewp);
		pend_t p;
		p = '0;
		p.t.start = ts;
		p.t.len   = off - ts;
		p.t.line  = ln;
		unique case (m)
			M_OP: begin
				p.vld = op != OP_NONE;
				unique case (op)
					OP_GT:     p.t.kind = K_GT;
					OP_LT:     p.t.kind = K_LT;
					OP_ASSIGN: p.t.kind = K_ASSIGN;
					OP_STAR:   p.t.kind = K_STAR;
					OP_SLASH:  p.t.kind = K_SLASH;
					OP_BANG: begin
						p.t.kind = K_ERR;
						p.t.err  = E_UNKNOWN;
					end
					default:   p.t.kind = K_EOF;
				endcase
			end
			M_DOT: begin
				p.vld = 1'b1;
				p.t.kind = K_DOT;
			end
			M_STRING: begin
				p.vld = 1'b1;
				p.t.kind = K_ERR;
				p.t.err  = E_UNTERM;
			end
			M_IDENT: begin
				p.vld = 1'b1;
				p.t.kind = K_IDENT;
			end
			M_INT: begin
				p.vld = 1'b1;
				p.t.kind = K_INT;
				p.t.val  = acc[30:0];
				p.t.err  = ov ? E_OVERFLOW : E_NONE;
			end
			M_FRAC: begin
				p.vld = 1'b1;
				if (ewp) begin
					p.t.kind = K_ERR;
					p.t.err  = E_ENDPOINT;
				end else begin
					p.t.kind = K_DEC;
					p.t.err  = ex ? E_EXTRAPT : E_NONE;
				end
			end
			default: p.vld = 1'b0;
		endcase
		return p;
	endfunction

	assign room     = cnt_q <= (PTR_BITS+1)'(FIFO_DEPTH - 3);
	assign proc     = valid_s1 & room;
	assign in_stall = valid_s1 & ~room;
	assign pop      = out_valid & ~out_stall;

	always_comb begin
		logic [7:0]  c;
		logic        fin;
		logic [4:0]  pk;
		logic [4:0]  sk;
		op_t         oc;
		logic [35:0] v;
		pend_t       p;
		c     = sym_s1;
		fin   = 1'b0;
		pk    = K_EOF;
		sk    = K_EOF;
		oc    = OP_NONE;
		v     = '0;
		p     = '0;
		m_n   = mode_q;
		op_n  = op_q;
		off_n = off_q;
		ts_n  = ts_q;
		ln_n  = ln_q;
		acc_n = acc_q;
		ov_n  = ov_q;
		ex_n  = ex_q;
		ewp_n = ewp_q;
		n_em  = 2'd0;
		for (int i = 0; i < 3; i++) em[i] = '0;

		if (has_s1) begin
			unique case (m_n)
				M_OP: begin
					if (c == "=") begin
						unique case (op_n)
							OP_GT:     pk = K_GE;
							OP_LT:     pk = K_LE;
							OP_ASSIGN: pk = K_EQ;
							OP_BANG:   pk = K_NE;
							default:   pk = K_EOF;
						endcase
					end else if (c == "*" && op_n == OP_STAR) begin
						pk = K_POW;
					end
					if (c == "/" && op_n == OP_SLASH) begin
						m_n  = M_COMMENT;
						op_n = OP_NONE;
					end else if (pk != K_EOF) begin
						em[n_em] = '{kind: pk, start: ts_n, len: off_n - ts_n + 1'b1,
							line: ln_n, val: '0, err: E_NONE};
						n_em = n_em + 2'd1;
						m_n  = M_IDLE;
						op_n = OP_NONE;
					end else begin
						fin = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(c)) begin
						m_n   = M_FRAC;
						ex_n  = 1'b0;
						ewp_n = 1'b0;
					end else begin
						fin = 1'b1;
					end
				end
				M_STRING: begin
					if (c == "\"") begin
						em[n_em] = '{kind: K_STRING, start: ts_n,
							len: off_n - ts_n + 1'b1, line: ln_n, val: '0, err: E_NONE};
						n_em = n_em + 2'd1;
						m_n  = M_IDLE;
					end else if (c == "\n" && ln_n != '1) begin
						ln_n = ln_n + 1'b1;
					end
				end
				M_IDENT: fin = !(is_alpha(c) || is_digit(c));
				M_INT: begin
					if (is_digit(c)) begin
						v = {4'd0, acc_n} * 36'd10 + 36'(c - "0");
						if (v > 36'h07FFFFFFF) ov_n = 1'b1;
						acc_n = v[31:0];
					end else if (c == ".") begin
						m_n   = M_FRAC;
						ewp_n = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_digit(c)) begin
						ewp_n = 1'b0;
					end else if (c == ".") begin
						ex_n  = 1'b1;
						ewp_n = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == "\n") begin
						m_n = M_IDLE;
						fin = 1'b1;
					end
				end
				default: fin = 1'b1;
			endcase

			if (fin) begin
				p = pending(m_n, op_n, ts_n, off_n, ln_n, acc_n, ov_n, ex_n, ewp_n);
				if (p.vld) begin
					em[n_em] = p.t;
					n_em = n_em + 2'd1;
				end
				m_n  = M_IDLE;
				op_n = OP_NONE;
				// scan the ending byte afresh
				ts_n = off_n;
				sk   = single_kind(c);
				oc   = op_code(c);
				if (sk != K_EOF) begin
					em[n_em] = '{kind: sk, start: ts_n, len: OFFSET_BITS'(1),
						line: ln_n, val: '0, err: E_NONE};
					n_em = n_em + 2'd1;
				end else if (oc != OP_NONE) begin
					m_n  = M_OP;
					op_n = oc;
				end else if (c == ".") begin
					m_n = M_DOT;
				end else if (c == "\"") begin
					m_n = M_STRING;
				end else if (c == "\n") begin
					if (ln_n != '1) ln_n = ln_n + 1'b1;
				end else if (c == "\t" || c == "\r" || c == " ") begin
					m_n = M_IDLE;
				end else if (is_alpha(c)) begin
					m_n = M_IDENT;
				end else if (is_digit(c)) begin
					m_n   = M_INT;
					acc_n = 32'(c - "0");
					ov_n  = 1'b0;
					ex_n  = 1'b0;
					ewp_n = 1'b0;
				end else begin
					em[n_em] = '{kind: K_ERR, start: ts_n, len: OFFSET_BITS'(1),
						line: ln_n, val: '0, err: E_UNKNOWN};
					n_em = n_em + 2'd1;
				end
			end
			off_n = off_n + 1'b1;
		end

		if (eos_s1) begin
			p = pending(m_n, op_n, ts_n, off_n, ln_n, acc_n, ov_n, ex_n, ewp_n);
			if (p.vld) begin
				em[n_em] = p.t;
				n_em = n_em + 2'd1;
			end
			em[n_em] = '{kind: K_EOF, start: off_n, len: '0, line: ln_n,
				val: '0, err: E_NONE};
			n_em  = n_em + 2'd1;
			m_n   = M_IDLE;
			op_n  = OP_NONE;
			off_n = '0;
			ts_n  = '0;
			ln_n  = LINE_BITS'(1);
			acc_n = '0;
			ov_n  = 1'b0;
			ex_n  = 1'b0;
			ewp_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sym_s1 <= symbol;
			has_s1 <= has_symbol;
			eos_s1 <= end_of_source;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			op_q   <= OP_NONE;
			off_q  <= '0;
			ts_q   <= '0;
			ln_q   <= LINE_BITS'(1);
			acc_q  <= '0;
			ov_q   <= 1'b0;
			ex_q   <= 1'b0;
			ewp_q  <= 1'b0;
		end else if (proc) begin
			mode_q <= m_n;
			op_q   <= op_n;
			off_q  <= off_n;
			ts_q   <= ts_n;
			ln_q   <= ln_n;
			acc_q  <= acc_n;
			ov_q   <= ov_n;
			ex_q   <= ex_n;
			ewp_q  <= ewp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < n_em) begin
					mem_q[wr_q + PTR_BITS'(i)] <= '{t: em[i], last: 2'(i + 1) == n_em};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (proc) wr_q <= wr_q + PTR_BITS'(n_em);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PTR_BITS+1)'(proc ? n_em : 2'd0) - (PTR_BITS+1)'(pop);
		end
	end

	assign out_valid     = cnt_q != '0;
	assign token_kind    = mem_q[rd_q].t.kind;
	assign start_offset  = mem_q[rd_q].t.start;
	assign lexeme_length = mem_q[rd_q].t.len;
	assign line_number   = mem_q[rd_q].t.line;
	assign integer_value = mem_q[rd_q].t.val;
	assign error_code    = mem_q[rd_q].t.err;
	assign last_of_run   = mem_q[rd_q].last;

endmodule

FILE: design/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the tokenizer output stream.
// ----------------------------------------------------------------------------
module stt_checker import stt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [4:0]             token_kind,
	input logic [OFFSET_BITS-1:0] lexeme_length,
	input logic [30:0]            integer_value,
	input logic [2:0]             error_code,
	input logic                   last_of_run
);

	// a held word keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind)
			&& $stable(lexeme_length) && $stable(last_of_run))
		else $error("stalled output word changed");

	// eof closes its run and carries no lexeme
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_EOF |-> last_of_run && lexeme_length == '0)
		else $error("eof word malformed");

	// error-only words carry one of the lexical error codes
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_ERR |->
			(error_code == E_UNKNOWN || error_code == E_UNTERM
				|| error_code == E_ENDPOINT))
		else $error("error word without error code");

	// only integer tokens carry a value
	a_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != K_INT |-> integer_value == '0)
		else $error("value on non-integer token");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.token_kind    (token_kind),
	.lexeme_length (lexeme_length),
	.integer_value (integer_value),
	.error_code    (error_code),
	.last_of_run   (last_of_run)
);

FILE: dv/source_text_tokenizer_top_test.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_test
// Self-checking bench for the streaming tokenizer: a predictor builds the
// expected tokens for every accepted input word and a scoreboard checks each
// output word against them, with random input idle and random output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module source_text_tokenizer_top_test;
	import stt_pkg::*;

	localparam int MODE_IDLE    = 0;
	localparam int MODE_OP      = 1;
	localparam int MODE_DOT     = 2;
	localparam int MODE_STRING  = 3;
	localparam int MODE_IDENT   = 4;
	localparam int MODE_INT     = 5;
	localparam int MODE_FRAC    = 6;
	localparam int MODE_COMMENT = 7;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		tok_t tok;
		logic last;
	} token_word_t;

	class token_scoreboard;
		token_word_t pending_tokens[$];
		int          n_errors;
		int          mode;
		op_t         held_op;
		logic [OFFSET_BITS-1:0] offset, tok_start;
		logic [LINE_BITS-1:0]   line;
		logic [31:0] acc;
		logic        ovf, extra_pt, ends_pt;
		token_word_t word_toks[$];

		function new();
			n_errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			mode = MODE_IDLE;
			held_op = OP_NONE;
			offset = '0;
			tok_start = '0;
			line = LINE_BITS'(1);
			acc = '0;
			ovf = 0;
			extra_pt = 0;
			ends_pt = 0;
		endfunction

		function void push_tok(logic [4:0] k, logic [OFFSET_BITS-1:0] s,
				logic [OFFSET_BITS-1:0] l, logic [30:0] v, logic [2:0] e);
			token_word_t t;
			t.tok.kind = k;
			t.tok.start = s;
			t.tok.len = l;
			t.tok.line = line;
			t.tok.val = v;
			t.tok.err = e;
			t.last = 0;
			word_toks = {word_toks, t};
		endfunction

		function logic [OFFSET_BITS-1:0] span_len();
			return offset - tok_start;
		endfunction

		function void bump_line();
			if (line != {LINE_BITS{1'b1}})
				line = line + 1'b1;
		endfunction

		function void flush_token();
			case (mode)
				MODE_OP: begin
					case (held_op)
						OP_BANG:   push_tok(K_ERR, tok_start, span_len(), 0, E_UNKNOWN);
						OP_GT:     push_tok(K_GT, tok_start, span_len(), 0, E_NONE);
						OP_LT:     push_tok(K_LT, tok_start, span_len(), 0, E_NONE);
						OP_ASSIGN: push_tok(K_ASSIGN, tok_start, span_len(), 0, E_NONE);
						OP_STAR:   push_tok(K_STAR, tok_start, span_len(), 0, E_NONE);
						OP_SLASH:  push_tok(K_SLASH, tok_start, span_len(), 0, E_NONE);
						default: ;
					endcase
				end
				MODE_DOT: push_tok(K_DOT, tok_start, span_len(), 0, E_NONE);
				MODE_STRING: push_tok(K_ERR, tok_start, span_len(), 0, E_UNTERM);
				MODE_IDENT: push_tok(K_IDENT, tok_start, span_len(), 0, E_NONE);
				MODE_INT: push_tok(K_INT, tok_start, span_len(), acc[30:0],
					ovf ? E_OVERFLOW : E_NONE);
				MODE_FRAC: begin
					if (ends_pt)
						push_tok(K_ERR, tok_start, span_len(), 0, E_ENDPOINT);
					else
						push_tok(K_DEC, tok_start, span_len(), 0,
							extra_pt ? E_EXTRAPT : E_NONE);
				end
				default: ;
			endcase
			mode = MODE_IDLE;
			held_op = OP_NONE;
		endfunction

		function void begin_byte(logic [7:0] c);
			logic [4:0] k;
			op_t o;
			k = 0;
			o = OP_NONE;
			tok_start = offset;
			case (c)
				"(": k = 1;  ")": k = 2;  "[": k = 3;  "]": k = 4;
				"{": k = 5;  "}": k = 6;  ",": k = 7;  ";": k = 8;
				"+": k = 9;  "-": k = 10; "%": k = 11;
				">": o = OP_GT;     "<": o = OP_LT;
				"=": o = OP_ASSIGN; "!": o = OP_BANG;
				"*": o = OP_STAR;   "/": o = OP_SLASH;
				default: ;
			endcase
			if (k != 0) begin
				push_tok(k, tok_start, 1, 0, E_NONE);
			end else if (o != OP_NONE) begin
				mode = MODE_OP;
				held_op = o;
			end else if (c == ".") begin
				mode = MODE_DOT;
			end else if (c == "\"") begin
				mode = MODE_STRING;
			end else if (c == 8'h0a) begin
				bump_line();
			end else if (c == 8'h09 || c == 8'h0d || c == " ") begin
			end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
				mode = MODE_IDENT;
			end else if (c >= "0" && c <= "9") begin
				mode = MODE_INT;
				acc = 32'(c - "0");
				ovf = 0;
				extra_pt = 0;
				ends_pt = 0;
			end else begin
				push_tok(K_ERR, tok_start, 1, 0, E_UNKNOWN);
			end
		endfunction

		function void scan_byte(logic [7:0] c);
			logic [4:0] pk;
			logic [63:0] v;
			logic dig, alpha;
			dig = c >= "0" && c <= "9";
			alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
			pk = 0;
			case (mode)
				MODE_OP: begin
					if (c == "=") begin
						case (held_op)
							OP_GT:     pk = K_GE;
							OP_LT:     pk = K_LE;
							OP_ASSIGN: pk = K_EQ;
							OP_BANG:   pk = K_NE;
							default: ;
						endcase
					end else if (c == "*" && held_op == OP_STAR) begin
						pk = K_POW;
					end else if (c == "/" && held_op == OP_SLASH) begin
						mode = MODE_COMMENT;
						held_op = OP_NONE;
						return;
					end
					if (pk != 0) begin
						push_tok(pk, tok_start, span_len() + 1'b1, 0, E_NONE);
						mode = MODE_IDLE;
						held_op = OP_NONE;
						return;
					end
				end
				MODE_DOT: begin
					if (dig) begin
						mode = MODE_FRAC;
						extra_pt = 0;
						ends_pt = 0;
						return;
					end
				end
				MODE_STRING: begin
					if (c == "\"") begin
						push_tok(K_STRING, tok_start, span_len() + 1'b1, 0, E_NONE);
						mode = MODE_IDLE;
					end else if (c == 8'h0a) begin
						bump_line();
					end
					return;
				end
				MODE_IDENT: if (alpha || dig) return;
				MODE_INT: begin
					if (dig) begin
						v = {32'd0, acc} * 64'd10 + 64'(c - "0");
						if (v > 64'h7fffffff) ovf = 1;
						acc = v[31:0];
						return;
					end
					if (c == ".") begin
						mode = MODE_FRAC;
						ends_pt = 1;
						return;
					end
				end
				MODE_FRAC: begin
					if (dig) begin
						ends_pt = 0;
						return;
					end
					if (c == ".") begin
						extra_pt = 1;
						ends_pt = 1;
						return;
					end
				end
				MODE_COMMENT: begin
					if (c != 8'h0a) return;
					mode = MODE_IDLE;
				end
				default: ;
			endcase
			flush_token();
			begin_byte(c);
		endfunction

		function void note_input(logic [7:0] c, logic has_c, logic eos);
			word_toks.delete();
			if (has_c) begin
				scan_byte(c);
				offset = offset + 1'b1;
			end
			if (eos) begin
				flush_token();
				push_tok(K_EOF, offset, 0, 0, E_NONE);
				clear_scan();
			end
			if (word_toks.size() > 0)
				word_toks[$].last = 1;
			pending_tokens = {pending_tokens, word_toks};
		endfunction

		function void check_token(token_word_t got);
			token_word_t want;
			if (pending_tokens.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected token word, actual %p", $realtime, got);
				return;
			end
			want = pending_tokens.pop_front();
			if (got.tok.kind !== want.tok.kind)
				report("kind", 32'(want.tok.kind), 32'(got.tok.kind));
			if (got.tok.start !== want.tok.start)
				report("start", 32'(want.tok.start), 32'(got.tok.start));
			if (got.tok.len !== want.tok.len)
				report("length", 32'(want.tok.len), 32'(got.tok.len));
			if (got.tok.line !== want.tok.line)
				report("line", 32'(want.tok.line), 32'(got.tok.line));
			if (got.tok.val !== want.tok.val)
				report("value", 32'(want.tok.val), 32'(got.tok.val));
			if (got.tok.err !== want.tok.err)
				report("error", 32'(want.tok.err), 32'(got.tok.err));
			if (got.last !== want.last)
				report("last", 32'(want.last), 32'(got.last));
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			n_errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $realtime, what, want, got);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [7:0] symbol = 0;
	logic has_symbol = 0;
	logic end_of_source = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [4:0] token_kind;
	logic [OFFSET_BITS-1:0] start_offset, lexeme_length;
	logic [LINE_BITS-1:0] line_number;
	logic [30:0] integer_value;
	logic [2:0] error_code;
	logic last_of_run;

	token_scoreboard sb = new();
	int  idle_pct = 38;
	int  cycles = 0;

	source_text_tokenizer_top i_dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("source_text_tokenizer_top regression: fail");
			$finish;
		end
	end

	// sample both channels at the edge, before the drivers update
	always @(posedge clk) begin
		token_word_t got;
		if (arst_n && in_valid && !in_stall)
			sb.note_input(symbol, has_symbol, end_of_source);
		if (arst_n && out_valid && !out_stall) begin
			got.tok.kind = token_kind;
			got.tok.start = start_offset;
			got.tok.len = lexeme_length;
			got.tok.line = line_number;
			got.tok.val = integer_value;
			got.tok.err = error_code;
			got.last = last_of_run;
			sb.check_token(got);
		end
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	task automatic send_word(logic [7:0] c, logic has_c, logic eos);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		symbol <= c;
		has_symbol <= has_c;
		end_of_source <= eos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_word(s[i], 1, 0);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending_tokens.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(9))
			0, 1: return 8'("a" + $urandom_range(25));
			2, 3: return 8'("0" + $urandom_range(9));
			4: return ".";
			5: return " ";
			6: return 8'h0a;
			7: begin
				case ($urandom_range(6))
					0: return "\"";
					1: return "/";
					2: return "=";
					3: return "!";
					4: return "*";
					5: return "<";
					default: return ">";
				endcase
			end
			8: return 8'("(" + $urandom_range(7));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	initial begin
		int n;
		logic [7:0] c;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_text("([]{},;+-%>>=<<===!=!x**");
		send_text(" 2147483647 4294967296 1.5 .25 3. 1.2.3 id_9 // c\n");
		send_text("\"a\nb\" / * @");
		send_word(8'hff, 1, 0);
		send_word(8'h00, 0, 0);
		send_word("\"", 1, 1);
		drain();

		n = 0;
		while (n < 220) begin
			idle_pct = (n > 100 && n < 160) ? 0 : 38;
			if ($urandom_range(15) == 0) begin
				send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1);
			end else begin
				c = pick_char();
				send_word(c, 1, 0);
			end
			n++;
			if (n == 180)
				drain();
		end
		send_word(8'h00, 0, 1);
		drain();
		repeat (20) @(posedge clk);
		if (sb.n_errors == 0 && sb.pending_tokens.size() == 0)
			$display("source_text_tokenizer_top regression: pass");
		else
			$display("source_text_tokenizer_top regression: fail");
		$finish;
	end
endmodule
